// ----- rtl/lks_pkg.sv -----
// Shared types and constants of the LRU key cache tag store.
package lks_pkg;

  localparam int KEY_W  = 64;
  localparam int HALF_W = 32;
  localparam int FUNC_W = 2;
  localparam int SLOT_W = 6;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // per-cell update controls
  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

endpackage

// ----- rtl/lks_cell.sv -----
// One recency position of the LRU chain: key, valid bit and slot id.
module lks_cell #(
  parameter int SW = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SW-1:0]            rst_slot,
  input  lks_pkg::cell_ctl_t       ctl,
  input  logic [lks_pkg::KEY_W-1:0] nb_key,
  input  logic                     nb_valid,
  input  logic [SW-1:0]            nb_slot,
  input  logic [lks_pkg::KEY_W-1:0] cmp_key,
  output logic [lks_pkg::KEY_W-1:0] key,
  output logic                     valid,
  output logic [SW-1:0]            slot,
  output logic                     match
);

  logic [lks_pkg::KEY_W-1:0] key_r;
  logic                      valid_r;
  logic [SW-1:0]             slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= rst_slot;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= nb_valid;
      slot_r  <= nb_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift && !ctl.clr) begin
      key_r <= nb_key;
    end
  end

  assign key   = key_r;
  assign valid = valid_r;
  assign slot  = slot_r;
  assign match = valid_r && (key_r == cmp_key);

endmodule

// ----- rtl/lru_key_cache_tag_store.sv -----
// Top level of the LRU key cache tag store: cell chain and request control.
//
// Usage: a request carries func (lookup, insert, flush) and a 64-bit key split
// in two words; every request returns exactly one result (hit, slot, evicted).
// Both channels use valid/ready and a transfer happens when both are high.
// The slots live in a chain of ENTRIES cells ordered by recency, the oldest
// at the bottom; promoting an entry shifts every cell above it down by one
// and loads the promoted entry into the top cell.
// The key is compared against all cells in the accept cycle; the chain shifts
// and the result register loads when the execute state commits, which waits
// for the result register to be free. A new request is accepted only once the
// previous one has committed and the control is back in idle.
// A waiting result sits in the output register; the next request can be
// accepted meanwhile, and its update waits until that register frees up.
// Reset: all slots invalid, cell i holds slot i, so slot 0 is the oldest.
module lru_key_cache_tag_store #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lks_pkg::FUNC_W-1:0]    in_func,
  input  logic [lks_pkg::HALF_W-1:0]    in_key_low,
  input  logic [lks_pkg::HALF_W-1:0]    in_key_high,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [lks_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_evicted
);

  localparam int SW = $clog2(ENTRIES);
  localparam int OW = (SW > lks_pkg::SLOT_W) ? SW : lks_pkg::SLOT_W;

  lks_pkg::state_t state_r, state_nxt;

  logic [lks_pkg::FUNC_W-1:0] func_r;
  logic [lks_pkg::KEY_W-1:0]  key_r;
  logic [ENTRIES-1:0]         match_r;
  logic [lks_pkg::KEY_W-1:0]  in_key;

  logic [lks_pkg::KEY_W-1:0] cell_key   [ENTRIES];
  logic [SW-1:0]             cell_slot  [ENTRIES];
  logic [ENTRIES-1:0]        cell_valid;
  logic [ENTRIES-1:0]        cell_match;
  lks_pkg::cell_ctl_t        cell_ctl   [ENTRIES];

  logic [ENTRIES-1:0] above;
  logic [ENTRIES-1:0] sel;
  logic [SW-1:0]      sel_slot [ENTRIES];
  logic [SW-1:0]      hit_slot;
  logic               any_hit;

  logic               accept;
  logic               commit;
  logic               is_lookup, is_insert, is_flush;
  logic               top_valid;
  logic [SW-1:0]      top_slot;

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [SW-1:0]      out_slot_r, out_slot_nxt;
  logic               out_evicted_r, out_evicted_nxt;
  logic [OW-1:0]      slot_ext;

  assign in_key = {in_key_high, in_key_low};
  assign accept = in_valid && in_ready;

  // find the most recent matching cell
  assign any_hit = |match_r;
  assign above[ENTRIES-1] = 1'b0;
  for (genvar p = 0; p < ENTRIES - 1; p++) begin : g_above
    assign above[p] = above[p+1] | match_r[p+1];
  end
  assign sel = match_r & ~above;

  assign sel_slot[0] = sel[0] ? cell_slot[0] : '0;
  for (genvar p = 1; p < ENTRIES; p++) begin : g_sel
    assign sel_slot[p] = sel_slot[p-1] | (sel[p] ? cell_slot[p] : '0);
  end
  assign hit_slot = sel_slot[ENTRIES-1];

  always_comb begin
    is_lookup = 1'b0;
    is_insert = 1'b0;
    is_flush  = 1'b0;
    unique case (func_r)
      lks_pkg::FUNC_LOOKUP: is_lookup = 1'b1;
      lks_pkg::FUNC_INSERT: is_insert = 1'b1;
      lks_pkg::FUNC_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  // entry that lands in the top cell
  assign top_valid = 1'b1;
  assign top_slot  = is_insert ? cell_slot[0] : hit_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lks_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      lks_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = lks_pkg::ST_EXEC;
        end
      end
      lks_pkg::ST_EXEC: begin
        // hold the update until the result register is free
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = lks_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lks_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      key_r   <= in_key;
      match_r <= cell_match;
    end
  end

  for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
    logic [lks_pkg::KEY_W-1:0] nb_key;
    logic                      nb_valid;
    logic [SW-1:0]             nb_slot;

    if (p == ENTRIES - 1) begin : g_top
      assign nb_key   = key_r;
      assign nb_valid = top_valid;
      assign nb_slot  = top_slot;
    end else begin : g_mid
      assign nb_key   = cell_key[p+1];
      assign nb_valid = cell_valid[p+1];
      assign nb_slot  = cell_slot[p+1];
    end

    assign cell_ctl[p].shift = commit &&
                               (is_insert || (is_lookup && any_hit && !above[p]));
    assign cell_ctl[p].clr   = commit && is_flush;

    lks_cell #(
      .SW(SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rst_slot (SW'(p)),
      .ctl      (cell_ctl[p]),
      .nb_key   (nb_key),
      .nb_valid (nb_valid),
      .nb_slot  (nb_slot),
      .cmp_key  (in_key),
      .key      (cell_key[p]),
      .valid    (cell_valid[p]),
      .slot     (cell_slot[p]),
      .match    (cell_match[p])
    );
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_hit_nxt     = out_hit_r;
    out_slot_nxt    = out_slot_r;
    out_evicted_nxt = out_evicted_r;
    if (commit) begin
      out_valid_nxt   = 1'b1;
      out_hit_nxt     = is_lookup && any_hit;
      out_evicted_nxt = is_insert && cell_valid[0];
      if (is_insert) begin
        out_slot_nxt = cell_slot[0];
      end else if (is_lookup && any_hit) begin
        out_slot_nxt = hit_slot;
      end else begin
        out_slot_nxt = '0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r     <= out_hit_nxt;
    out_slot_r    <= out_slot_nxt;
    out_evicted_r <= out_evicted_nxt;
  end

  assign slot_ext    = OW'(out_slot_r);
  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_slot    = slot_ext[lks_pkg::SLOT_W-1:0];
  assign out_evicted = out_evicted_r;

`ifndef SYNTH
  a_insert_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && is_insert) |=> cell_valid[ENTRIES-1])
    else $error("inserted entry not valid in top cell");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && is_flush) |=> (cell_valid == '0))
    else $error("flush left a valid cell");

  a_hit_promoted: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && is_lookup && any_hit) |=> (cell_slot[ENTRIES-1] == $past(hit_slot)))
    else $error("hit slot not promoted to top cell");

  a_single_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lks_pkg::ST_EXEC) |-> $onehot0(sel))
    else $error("more than one selected cell");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the LRU key cache tag store: directed cases, then random traffic.
`timescale 1ns / 1ps

module testbench;

  localparam int ENTRIES     = 64;
  localparam int MAX_WAIT    = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int HISTORY_MAX = 96;
  localparam logic [lks_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic                       hit;
    logic [lks_pkg::SLOT_W-1:0] slot;
    logic                       evicted;
  } tag_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [lks_pkg::FUNC_W-1:0] in_func;
  logic [lks_pkg::HALF_W-1:0] in_key_low;
  logic [lks_pkg::HALF_W-1:0] in_key_high;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_hit;
  logic [lks_pkg::SLOT_W-1:0] out_slot;
  logic                       out_evicted;

  // shadow copy of the tag store
  logic [lks_pkg::KEY_W-1:0]  shadow_key  [ENTRIES];
  bit                         shadow_valid[ENTRIES];
  logic [lks_pkg::SLOT_W-1:0] shadow_rank [ENTRIES];

  tag_result_t               pending_results[$];
  logic [lks_pkg::KEY_W-1:0] inserted_keys[$];
  int                        error_count = 0;
  int                        cycle_count = 0;
  bit                        no_idle = 1'b0;

  lru_key_cache_tag_store #(.ENTRIES(ENTRIES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_key_low (in_key_low),
    .in_key_high(in_key_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_slot   (out_slot),
    .out_evicted(out_evicted)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void clear_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = lks_pkg::SLOT_W'(i);
    end
  endfunction

  // Move slot s to the top; every slot ranked above it drops one.
  function automatic void promote_slot(int s);
    logic [lks_pkg::SLOT_W-1:0] old_rank;
    old_rank = shadow_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_rank[i] > old_rank) shadow_rank[i] = shadow_rank[i] - 1'b1;
    shadow_rank[s] = lks_pkg::SLOT_W'(ENTRIES - 1);
  endfunction

  function automatic tag_result_t predict_tag_access(
      logic [lks_pkg::FUNC_W-1:0] func,
      logic [lks_pkg::HALF_W-1:0] key_low,
      logic [lks_pkg::HALF_W-1:0] key_high);
    tag_result_t               res;
    logic [lks_pkg::KEY_W-1:0] key;
    int                        best;
    int                        victim;
    res    = '0;
    key    = {key_high, key_low};
    best   = -1;
    victim = 0;
    case (func)
      lks_pkg::FUNC_LOOKUP: begin
        // newest matching copy wins
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i] && shadow_key[i] == key)
            if (best < 0 || shadow_rank[i] > shadow_rank[best]) best = i;
        if (best >= 0) begin
          promote_slot(best);
          res.hit  = 1'b1;
          res.slot = lks_pkg::SLOT_W'(best);
        end
      end
      lks_pkg::FUNC_INSERT: begin
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (shadow_rank[i] == '0) victim = i;
        res.evicted          = shadow_valid[victim];
        shadow_key[victim]   = key;
        shadow_valid[victim] = 1'b1;
        promote_slot(victim);
        res.slot = lks_pkg::SLOT_W'(victim);
      end
      lks_pkg::FUNC_FLUSH: begin
        for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(input logic [lks_pkg::FUNC_W-1:0] func,
                              input logic [lks_pkg::HALF_W-1:0] key_low,
                              input logic [lks_pkg::HALF_W-1:0] key_high);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_key_low  <= key_low;
    in_key_high <= key_high;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_tag_access(func, key_low, key_high));
    if (func == lks_pkg::FUNC_INSERT) begin
      inserted_keys.push_back({key_high, key_low});
      if (inserted_keys.size() > HISTORY_MAX) void'(inserted_keys.pop_front());
    end
  endtask

  // Hold off new requests until every outstanding result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: draw a stall per result, then hold ready until it is taken.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    tag_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: hit %0d slot %0d evicted %0d",
               out_hit, out_slot, out_evicted);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit mismatch: expected %0d, actual %0d", want.hit, out_hit);
          error_count++;
        end
        if (out_slot !== want.slot) begin
          $error("out_slot mismatch: expected %0d, actual %0d", want.slot, out_slot);
          error_count++;
        end
        if (out_evicted !== want.evicted) begin
          $error("out_evicted mismatch: expected %0d, actual %0d",
                 want.evicted, out_evicted);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_store();
    // reset leaves every cell invalid, so these miss
    send_request(lks_pkg::FUNC_LOOKUP, 32'h0, 32'h0);
    send_request(lks_pkg::FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_key_extremes();
    send_request(lks_pkg::FUNC_INSERT, 32'h0, 32'h0);
    send_request(lks_pkg::FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(lks_pkg::FUNC_INSERT, 32'hffff_ffff, 32'h0);
    send_request(lks_pkg::FUNC_INSERT, 32'h0, 32'hffff_ffff);
    send_request(lks_pkg::FUNC_LOOKUP, 32'h0, 32'h0);
    send_request(lks_pkg::FUNC_LOOKUP, 32'hffff_ffff, 32'h0);
    send_request(lks_pkg::FUNC_LOOKUP, 32'h0, 32'hffff_ffff);
    send_request(lks_pkg::FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
    send_request(lks_pkg::FUNC_LOOKUP, 32'hffff_fffe, 32'hffff_ffff);
  endtask

  task automatic test_duplicate_keys();
    send_request(lks_pkg::FUNC_INSERT, 32'h1234_5678, 32'h9abc_def0);
    send_request(lks_pkg::FUNC_INSERT, 32'h1234_5678, 32'h9abc_def0);
    send_request(lks_pkg::FUNC_LOOKUP, 32'h1234_5678, 32'h9abc_def0);
    send_request(lks_pkg::FUNC_LOOKUP, 32'h1234_5678, 32'h9abc_def0);
  endtask

  task automatic test_flush();
    send_request(lks_pkg::FUNC_FLUSH, 32'hffff_ffff, 32'hffff_ffff);
    send_request(lks_pkg::FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
    send_request(lks_pkg::FUNC_INSERT, 32'h5555_aaaa, 32'haaaa_5555);
    send_request(lks_pkg::FUNC_LOOKUP, 32'h5555_aaaa, 32'haaaa_5555);
  endtask

  task automatic test_unused_func();
    send_request(FUNC_UNUSED, 32'h5555_aaaa, 32'haaaa_5555);
    send_request(FUNC_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_request(lks_pkg::FUNC_LOOKUP, 32'h5555_aaaa, 32'haaaa_5555);
  endtask

  task automatic random_key(output logic [lks_pkg::HALF_W-1:0] key_low,
                            output logic [lks_pkg::HALF_W-1:0] key_high);
    // a few hot keys produce duplicates
    if ($urandom_range(0, 9) < 2) begin
      key_low  = $urandom_range(0, 7);
      key_high = '0;
    end else begin
      key_low  = $urandom;
      key_high = $urandom;
    end
  endtask

  task automatic random_request();
    int                         pick;
    logic [lks_pkg::HALF_W-1:0] key_low;
    logic [lks_pkg::HALF_W-1:0] key_high;
    logic [lks_pkg::KEY_W-1:0]  old_key;
    pick = $urandom_range(0, 99);
    random_key(key_low, key_high);
    if (pick < 55) begin
      if (inserted_keys.size() != 0 && $urandom_range(0, 99) < 70) begin
        old_key  = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        key_low  = old_key[lks_pkg::HALF_W-1:0];
        key_high = old_key[lks_pkg::KEY_W-1:lks_pkg::HALF_W];
      end
      send_request(lks_pkg::FUNC_LOOKUP, key_low, key_high);
    end else if (pick < 98) begin
      send_request(lks_pkg::FUNC_INSERT, key_low, key_high);
    end else if (pick < 99) begin
      send_request(lks_pkg::FUNC_FLUSH, key_low, key_high);
    end else begin
      send_request(FUNC_UNUSED, key_low, key_high);
    end
  endtask

  task automatic test_random_traffic();
    logic [lks_pkg::HALF_W-1:0] key_low;
    logic [lks_pkg::HALF_W-1:0] key_high;
    // fill past capacity so evictions of valid keys start early
    no_idle = 1'b1;
    for (int i = 0; i < 2 * ENTRIES + 6; i++) begin
      random_key(key_low, key_high);
      send_request(lks_pkg::FUNC_INSERT, key_low, key_high);
    end
    no_idle = 1'b0;
    for (int seg = 0; seg < 8; seg++) begin
      no_idle = (seg % 3 == 2);
      for (int i = 0; i < 95; i++) random_request();
      if (seg == 3) drain_results();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_func     <= lks_pkg::FUNC_LOOKUP;
    in_key_low  <= '0;
    in_key_high <= '0;
    rst_n       <= 1'b0;
    clear_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_key_extremes();
    test_duplicate_keys();
    test_flush();
    test_unused_func();
    drain_results();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
